[rtl/core/complex_domain_coloring_pixel_defines.svh]
// Assertion macros for the domain coloring pixel pipeline.
// Used by complex_domain_coloring_pixel; no other dependencies.
`ifndef COMPLEX_DOMAIN_COLORING_PIXEL_DEFINES_SVH
`define COMPLEX_DOMAIN_COLORING_PIXEL_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CDCP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define CDCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/cdcp_pkg.sv]
// Shared types, register indexes and constant tables for the domain coloring pixel.
// No dependencies.
`default_nettype none

package cdcp_pkg;

    typedef logic signed [15:0] t_q312;
    typedef logic [7:0]         t_byte;

    localparam int unsigned MAX_DIM      = 4096;
    localparam int unsigned CORDIC_STEPS = 15;

    localparam logic [2:0] REG_BASE_SCALE    = 3'd0;
    localparam logic [2:0] REG_ZOOM_SCALE    = 3'd1;
    localparam logic [2:0] REG_ZOOM_ENABLE   = 3'd2;
    localparam logic [2:0] REG_ZOOM_COL_LOW  = 3'd3;
    localparam logic [2:0] REG_ZOOM_COL_HIGH = 3'd4;
    localparam logic [2:0] REG_ZOOM_ROW_LOW  = 3'd5;
    localparam logic [2:0] REG_ZOOM_ROW_HIGH = 3'd6;
    localparam logic [2:0] REG_PHASE_OFFSET  = 3'd7;

    localparam logic [2:0] SECT_1 = 3'd1;
    localparam logic [2:0] SECT_2 = 3'd2;
    localparam logic [2:0] SECT_3 = 3'd3;
    localparam logic [2:0] SECT_4 = 3'd4;
    localparam logic [2:0] SECT_5 = 3'd5;

    // arctangent of 2^-i in 1/65536 turn
    function automatic logic [15:0] atan_turn(input int unsigned i);
        logic [15:0] a;
        case (i)
            0:       a = 16'd8192;
            1:       a = 16'd4836;
            2:       a = 16'd2555;
            3:       a = 16'd1297;
            4:       a = 16'd651;
            5:       a = 16'd326;
            6:       a = 16'd163;
            7:       a = 16'd81;
            8:       a = 16'd41;
            9:       a = 16'd20;
            10:      a = 16'd10;
            11:      a = 16'd5;
            12:      a = 16'd3;
            13:      a = 16'd1;
            14:      a = 16'd1;
            default: a = 16'd0;
        endcase
        return a;
    endfunction

    function automatic logic [31:0] energy(input t_q312 re, input t_q312 im);
        logic signed [31:0] p;
        logic signed [31:0] q;
        p = re * re;
        q = im * im;
        return unsigned'(p) + unsigned'(q);
    endfunction

endpackage

`default_nettype wire

[rtl/core/cdcp_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
// Standalone; caller guarantees the quotient fits in QW bits.
`default_nettype none

module cdcp_div #(
    parameter int NW = 48,
    parameter int DW = 41,
    parameter int QW = 17
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic      [QW-1:0] o_quo
);

    localparam int CW = (NW > DW) ? NW : DW;
    localparam int SW = CW + QW;

    logic [NW-1:0] r_rem [QW-1];
    logic [DW-1:0] r_den [QW-1];
    logic [QW-1:0] r_quo [QW];
    logic [NW-1:0] n_rem [QW-1];
    logic [DW-1:0] n_den [QW-1];
    logic [QW-1:0] n_quo [QW];

    always_comb begin
        logic [NW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic [SW-1:0] sub;
        logic          ge;
        for (int j = 0; j < QW; j++) begin
            if (j == 0) begin
                rem_in = i_num;
                den_in = i_den;
                quo_in = '0;
            end else begin
                rem_in = r_rem[j-1];
                den_in = r_den[j-1];
                quo_in = r_quo[j-1];
            end
            sub      = SW'(den_in) << (QW - 1 - j);
            ge       = CW'(rem_in >> (QW - 1 - j)) >= CW'(den_in);
            n_quo[j] = quo_in | (ge ? (QW'(1) << (QW - 1 - j)) : '0);
            if (j < QW - 1) begin
                n_rem[j] = ge ? rem_in - NW'(sub) : rem_in;
                n_den[j] = den_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_den <= n_den;
            r_quo <= n_quo;
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

`default_nettype wire

[rtl/core/cdcp_isqrt.sv]
// Pipelined integer square root, one root bit per stage.
// Standalone; input has twice the root width.
`default_nettype none

module cdcp_isqrt #(
    parameter int RW = 15
) (
    input  wire logic            i_clk,
    input  wire logic            i_en,
    input  wire logic [2*RW-1:0] i_val,
    output logic      [RW-1:0]   o_root
);

    localparam int NW = 2 * RW;
    localparam int XW = NW + 1;

    logic [NW-1:0] r_n   [RW-1];
    logic [XW-1:0] r_res [RW];
    logic [NW-1:0] n_n   [RW-1];
    logic [XW-1:0] n_res [RW];

    always_comb begin
        logic [NW-1:0] n_in;
        logic [XW-1:0] res_in;
        logic [XW-1:0] bitv;
        logic [XW-1:0] t;
        logic          ge;
        for (int j = 0; j < RW; j++) begin
            if (j == 0) begin
                n_in   = i_val;
                res_in = '0;
            end else begin
                n_in   = r_n[j-1];
                res_in = r_res[j-1];
            end
            bitv     = XW'(1) << (2 * (RW - 1 - j));
            t        = res_in + bitv;
            ge       = XW'(n_in) >= t;
            n_res[j] = ge ? (res_in >> 1) + bitv : res_in >> 1;
            if (j < RW - 1) begin
                n_n[j] = ge ? n_in - NW'(t) : n_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n   <= n_n;
            r_res <= n_res;
        end
    end

    assign o_root = RW'(r_res[RW-1]);

endmodule

`default_nettype wire

[rtl/core/complex_domain_coloring_pixel.sv]
// Top level of the domain coloring pixel pipeline: HSV color of one complex sample.
// Depends on cdcp_pkg, cdcp_div, cdcp_isqrt and the assertion macro header.
`default_nettype none
`include "complex_domain_coloring_pixel_defines.svh"

// One pixel request is taken every clock while o_ready is high; each yields one
// three-byte result, and results flow at one pixel per clock. The depth is set
// by the contour level path: a 30-stage divider followed by a 15-stage
// square root. A two-entry output buffer lets the pipeline keep moving while a
// result waits; when it is full the whole pipeline holds. Configuration writes
// are accepted whenever out of reset and should be made while no pixel is in flight.
module complex_domain_coloring_pixel
    import cdcp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_q312       i_center_re,
    input  wire t_q312       i_center_im,
    input  wire t_q312       i_left_re,
    input  wire t_q312       i_left_im,
    input  wire t_q312       i_right_re,
    input  wire t_q312       i_right_im,
    input  wire t_q312       i_upper_re,
    input  wire t_q312       i_upper_im,
    input  wire t_q312       i_lower_re,
    input  wire t_q312       i_lower_im,
    input  wire logic [11:0] i_pixel_row,
    input  wire logic [11:0] i_pixel_col,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_byte            o_byte_first,
    output t_byte            o_byte_second,
    output t_byte            o_byte_third
);

    localparam int LAST = 52;

    logic [15:0] r_base_scale;
    logic [15:0] r_zoom_scale;
    logic        r_zoom_enable;
    logic [11:0] r_zoom_col_low;
    logic [11:0] r_zoom_col_high;
    logic [11:0] r_zoom_row_low;
    logic [11:0] r_zoom_row_high;
    logic [15:0] r_phase_offset;

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_scale    <= 16'd256;
            r_zoom_scale    <= 16'd256;
            r_zoom_enable   <= 1'b0;
            r_zoom_col_low  <= 12'd0;
            r_zoom_col_high <= 12'd4095;
            r_zoom_row_low  <= 12'd0;
            r_zoom_row_high <= 12'd4095;
            r_phase_offset  <= 16'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_BASE_SCALE:    r_base_scale    <= i_cfg_data;
                REG_ZOOM_SCALE:    r_zoom_scale    <= i_cfg_data;
                REG_ZOOM_ENABLE:   r_zoom_enable   <= i_cfg_data[0];
                REG_ZOOM_COL_LOW:  r_zoom_col_low  <= i_cfg_data[11:0];
                REG_ZOOM_COL_HIGH: r_zoom_col_high <= i_cfg_data[11:0];
                REG_ZOOM_ROW_LOW:  r_zoom_row_low  <= i_cfg_data[11:0];
                REG_ZOOM_ROW_HIGH: r_zoom_row_high <= i_cfg_data[11:0];
                REG_PHASE_OFFSET:  r_phase_offset  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline control
    logic            w_en;
    logic [LAST:1]   r_vld;
    logic [1:0]      r_cnt;
    logic            w_push;
    logic            w_pop;

    assign w_en    = (r_cnt != 2'd2);
    assign o_ready = w_en && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAST-1:1], i_valid};
        end
    end

    // stage 1: energies, divisor select
    logic        w_inside;
    logic [15:0] w_mag_sel;
    logic [15:0] w_mag;
    logic [31:0] r1_s [5];
    logic [15:0] r1_mag;
    t_q312       r1_cre;
    t_q312       r1_cim;

    assign w_inside = r_zoom_enable
        && (32'(i_pixel_row) < MAX_DIM) && (32'(i_pixel_col) < MAX_DIM)
        && (i_pixel_row >= r_zoom_row_low) && (i_pixel_row <= r_zoom_row_high)
        && (i_pixel_col >= r_zoom_col_low) && (i_pixel_col <= r_zoom_col_high);
    assign w_mag_sel = w_inside ? r_zoom_scale : r_base_scale;
    assign w_mag     = (w_mag_sel == 16'd0) ? 16'd1 : w_mag_sel;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_s[0] <= energy(i_center_re, i_center_im);
            r1_s[1] <= energy(i_left_re, i_left_im);
            r1_s[2] <= energy(i_right_re, i_right_im);
            r1_s[3] <= energy(i_upper_re, i_upper_im);
            r1_s[4] <= energy(i_lower_re, i_lower_im);
            r1_mag  <= w_mag;
            r1_cre  <= i_center_re;
            r1_cim  <= i_center_im;
        end
    end

    // stage 2: divisor square, CORDIC prerotation
    logic        [31:0] r2_m;
    logic        [31:0] r2_s [5];
    logic signed [26:0] w_x0;
    logic signed [26:0] w_y0;
    logic signed [26:0] r_cx [2:17];
    logic signed [26:0] r_cy [2:17];
    logic        [15:0] r_ca [2:17];
    logic               r_cz [2:17];
    logic signed [26:0] n_cx [3:17];
    logic signed [26:0] n_cy [3:17];
    logic        [15:0] n_ca [3:17];

    assign w_x0 = {{3{r1_cre[15]}}, r1_cre, 8'b0};
    assign w_y0 = {{3{r1_cim[15]}}, r1_cim, 8'b0};

    // stages 3..17: CORDIC vectoring
    always_comb begin
        logic signed [26:0] dx;
        logic signed [26:0] dy;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = r_cy[2+i] >>> i;
            dy = r_cx[2+i] >>> i;
            if (r_cy[2+i] > 0) begin
                n_cx[3+i] = r_cx[2+i] + dx;
                n_cy[3+i] = r_cy[2+i] - dy;
                n_ca[3+i] = r_ca[2+i] + atan_turn(i);
            end else begin
                n_cx[3+i] = r_cx[2+i] - dx;
                n_cy[3+i] = r_cy[2+i] + dy;
                n_ca[3+i] = r_ca[2+i] - atan_turn(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_m    <= r1_mag * r1_mag;
            r2_s    <= r1_s;
            r_cz[2] <= (r1_cre == 16'sd0) && (r1_cim == 16'sd0);
            if (w_x0 < 0) begin
                r_cx[2] <= -w_x0;
                r_cy[2] <= -w_y0;
                r_ca[2] <= 16'h8000;
            end else begin
                r_cx[2] <= w_x0;
                r_cy[2] <= w_y0;
                r_ca[2] <= 16'h0000;
            end
            for (int i = 3; i <= 17; i++) begin
                r_cx[i] <= n_cx[i];
                r_cy[i] <= n_cy[i];
                r_ca[i] <= n_ca[i];
                r_cz[i] <= r_cz[i-1];
            end
        end
    end

    // stages 18..19: hue sector and fraction
    logic [15:0] r18_h;
    logic [18:0] r_kf [19:48];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r18_h    <= (r_cz[17] ? 16'd0 : r_ca[17]) + r_phase_offset + 16'h8000;
            r_kf[19] <= 19'(r18_h) * 19'd6;
            for (int i = 20; i <= 48; i++) begin
                r_kf[i] <= r_kf[i-1];
            end
        end
    end

    // stage 3: divider operands
    logic [47:0] r3_zn;
    logic [40:0] r3_zd;
    logic [37:0] r3_ln [5];
    logic [39:0] r3_ld;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_zn <= {r2_s[0], 16'b0};
            r3_zd <= 41'(r2_s[0]) + 41'({r2_m, 8'b0});
            r3_ld <= {r2_m, 8'b0};
            for (int i = 0; i < 5; i++) begin
                r3_ln[i] <= 38'(r2_s[i]) * 38'd100;
            end
        end
    end

    // stages 4..20: z = S/(S+256M), Q1.16
    logic [16:0] w_z;

    cdcp_div #(.NW(48), .DW(41), .QW(17)) u_zdiv (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r3_zn),
        .i_den (r3_zd),
        .o_quo (w_z)
    );

    // stage 21: value and saturation, then aligned to stage 48
    logic [16:0] w_v;
    logic [16:0] w_s;
    logic [16:0] w_zc;
    logic [33:0] r_vs [21:48];

    assign w_zc = 17'h10000 - w_z;
    assign w_v  = (w_z >= 17'd32768) ? 17'h10000 : {w_z[15:0], 1'b0};
    assign w_s  = (w_z <= 17'd32768) ? 17'h10000 : {w_zc[15:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_vs[21] <= {w_v, w_s};
            for (int i = 22; i <= 48; i++) begin
                r_vs[i] <= r_vs[i-1];
            end
        end
    end

    // stages 4..48: contour levels
    logic [29:0] w_lq  [5];
    logic [14:0] w_lvl [5];

    for (genvar g = 0; g < 5; g++) begin : g_level
        cdcp_div #(.NW(38), .DW(40), .QW(30)) u_ldiv (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r3_ln[g]),
            .i_den (r3_ld),
            .o_quo (w_lq[g])
        );
        cdcp_isqrt #(.RW(15)) u_lsqrt (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_val  (w_lq[g]),
            .o_root (w_lvl[g])
        );
    end

    // stage 49: contour dimming
    logic        w_differs;
    logic [16:0] w_s48;
    logic [16:0] w_sadj;
    logic [16:0] r49_v;
    logic [16:0] r49_s;
    logic [2:0]  r49_k;
    logic [15:0] r49_f;
    logic        r49_w;

    assign w_differs = (w_lvl[1] != w_lvl[0]) || (w_lvl[2] != w_lvl[0])
                    || (w_lvl[3] != w_lvl[0]) || (w_lvl[4] != w_lvl[0]);
    assign w_s48  = r_vs[48][16:0];
    assign w_sadj = !w_differs ? w_s48
                  : ((w_s48 > 17'd16384) ? w_s48 - 17'd16384 : 17'd0);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r49_v <= r_vs[48][33:17];
            r49_s <= w_sadj;
            r49_k <= r_kf[48][18:16];
            r49_f <= r_kf[48][15:0];
            r49_w <= (w_sadj == 17'd0);
        end
    end

    // stages 50..52: HSV to bytes
    logic [23:0] r50_a;
    logic [32:0] r50_sf;
    logic [32:0] r50_sg;
    logic [16:0] r50_ps;
    logic [2:0]  r50_k;
    logic        r50_w;
    logic [7:0]  r51_bv;
    logic [40:0] r51_ap;
    logic [32:0] r51_eq;
    logic [32:0] r51_et;
    logic [23:0] r51_a;
    logic [2:0]  r51_k;
    logic        r51_w;
    logic [56:0] w_pq;
    logic [56:0] w_pt;
    logic [7:0]  w_bq;
    logic [7:0]  w_bt;
    logic [7:0]  w_bp;
    logic [23:0] w_bytes;
    logic [23:0] r52_bytes;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r50_a  <= 24'(25'(r49_v) * 25'd255);
            r50_sf <= 33'(r49_s) * 33'(r49_f);
            r50_sg <= 33'(r49_s) * 33'(17'h10000 - 17'(r49_f));
            r50_ps <= 17'h10000 - r49_s;
            r50_k  <= r49_k;
            r50_w  <= r49_w;
            r51_bv <= r50_a[23:16];
            r51_ap <= 41'(r50_a) * 41'(r50_ps);
            r51_eq <= 33'h1_0000_0000 - r50_sf;
            r51_et <= 33'h1_0000_0000 - r50_sg;
            r51_a  <= r50_a;
            r51_k  <= r50_k;
            r51_w  <= r50_w;
        end
    end

    assign w_pq = 57'(r51_a) * 57'(r51_eq);
    assign w_pt = 57'(r51_a) * 57'(r51_et);
    assign w_bq = w_pq[55:48];
    assign w_bt = w_pt[55:48];
    assign w_bp = r51_ap[39:32];

    always_comb begin
        case (r51_k)
            SECT_1:  w_bytes = {r51_bv, w_bt, w_bp};
            SECT_2:  w_bytes = {w_bq, r51_bv, w_bp};
            SECT_3:  w_bytes = {w_bp, r51_bv, w_bt};
            SECT_4:  w_bytes = {w_bp, w_bq, r51_bv};
            SECT_5:  w_bytes = {w_bt, w_bp, r51_bv};
            default: w_bytes = {r51_bv, w_bp, w_bq};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r52_bytes <= r51_w ? 24'hFF_FFFF : w_bytes;
        end
    end

    // output buffer
    logic [23:0] r_fifo [2];
    logic        r_wp;
    logic        r_rp;

    assign w_push  = w_en && r_vld[LAST];
    assign o_valid = (r_cnt != 2'd0);
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wp] <= r52_bytes;
        end
    end

    assign o_byte_first  = r_fifo[r_rp][23:16];
    assign o_byte_second = r_fifo[r_rp][15:8];
    assign o_byte_third  = r_fifo[r_rp][7:0];

    `CDCP_ASSERT_NEXT(a_push_lands, i_clk, i_rst_n, w_push, r_cnt != 2'd0, "result lost at buffer")
    `CDCP_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, !w_en, $stable(r_vld), "pipeline moved in stall")
    `CDCP_ASSERT_SAME(a_no_overfill, i_clk, i_rst_n, r_cnt == 2'd2, !w_push, "push into full buffer")

endmodule

`default_nettype wire
